### hw/rtl/pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and byte helpers for the PNG stored RGB encoder.
// ---------------------------------------------------------------------------
package pse_pkg;

	localparam int DIM_W      = 14;
	localparam int COL_W      = 15;
	localparam int ROW_W      = 13;
	localparam int RAW_W      = 28;
	localparam int DIVD_W     = 29;
	localparam int BLK_W      = 16;
	localparam int IDX_W      = 4;
	localparam int STEP_W     = 6;
	localparam int CFG_IDX_W  = 2;

	// stored block size; the block count unit in pse_div is built for 2^16 - 1
	localparam int BLOCK_BYTES = 65535;

	localparam logic [31:0] CRC_POLY   = 32'hedb88320;
	localparam logic [31:0] ALL_ONES   = 32'hffffffff;
	localparam logic [16:0] ADLER_MOD  = 17'd65521;
	localparam logic [7:0]  ZLIB_CMF   = 8'h78;
	localparam logic [7:0]  ZLIB_FLG   = 8'h01;
	localparam logic [7:0]  IHDR_DEPTH = 8'd8;
	localparam logic [7:0]  IHDR_CTYPE = 8'd2;
	localparam logic [31:0] IHDR_LEN   = 32'd13;
	localparam logic [31:0] IEND_LEN   = 32'd0;
	localparam logic [STEP_W-1:0] MAX_WORDS = 6'd50;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
		8'd13, 8'd10, 8'd26, 8'd10};
	localparam logic [7:0] TAG_IHDR [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
	localparam logic [7:0] TAG_IDAT [4] = '{8'h49, 8'h44, 8'h41, 8'h54};
	localparam logic [7:0] TAG_IEND [4] = '{8'h49, 8'h45, 8'h4e, 8'h44};

	typedef enum logic [3:0] {
		SEC_NONE,
		SEC_SIG,
		SEC_LEN_IHDR,
		SEC_TAG_IHDR,
		SEC_IHDR_BODY,
		SEC_CRC,
		SEC_LEN_IDAT,
		SEC_TAG_IDAT,
		SEC_ZHDR,
		SEC_BLK_HDR,
		SEC_FILTER,
		SEC_PIXEL,
		SEC_ADLER,
		SEC_LEN_IEND,
		SEC_TAG_IEND
	} sec_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVS,
		ST_DIV,
		ST_SIG,
		ST_IHDR_LEN,
		ST_IHDR_TAG,
		ST_IHDR_BODY,
		ST_IHDR_CRC,
		ST_IDAT_LEN,
		ST_IDAT_TAG,
		ST_ZHDR,
		ST_RAW_DEC,
		ST_BLK_HDR,
		ST_FILTER,
		ST_PIXEL,
		ST_ADLER,
		ST_IDAT_CRC,
		ST_IEND_LEN,
		ST_IEND_TAG,
		ST_IEND_CRC,
		ST_WAIT
	} state_t;

	typedef struct packed {
		sec_t             sec;
		logic [IDX_W-1:0] idx;
		logic             emit;
		logic             drop;
		logic             last;
		logic             img_end;
		logic             start;
		logic             pix_load;
		logic             mul;
		logic             div_start;
		logic             len_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
		logic block_zero;
		logic col_zero;
		logic pix_last;
	} status_t;

	// CRC-32 (reflected) over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// big-endian byte of a 32-bit word
	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/pse_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pse_div
// Stored block count: divide by 2^16 - 1 with a shift-add, ready in the cycle
// after start.
// ---------------------------------------------------------------------------
module pse_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pse_pkg::DIVD_W-1:0]   dividend,
	output logic      [pse_pkg::DIVD_W-1:0]   quotient,
	output logic                              done
);

	logic [pse_pkg::DIVD_W:0]   sum;
	logic [pse_pkg::DIVD_W-1:0] quo_q;
	logic                       done_q;

	// x / 65535 = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
	assign sum = {1'b0, dividend} + {17'd0, dividend[pse_pkg::DIVD_W-1:16]} + 30'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// hold the quotient until the next start
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {15'd0, sum[pse_pkg::DIVD_W:16]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

### hw/rtl/pse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pse_ctrl
// Sequencer: walks the PNG sections and tells the datapath which byte to send.
// ---------------------------------------------------------------------------
module pse_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pse_pkg::status_t status,
	output pse_pkg::cmd_t         cmd
);

	pse_pkg::state_t             state_q, state_d;
	logic [pse_pkg::IDX_W-1:0]   idx_q;
	logic [pse_pkg::STEP_W-1:0]  step_q;
	logic                        pend_q;
	logic                        emitting;
	logic                        sec_done;
	logic [pse_pkg::IDX_W-1:0]   last_idx;
	pse_pkg::state_t             after;
	logic                        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				idx_q <= sec_done ? '0 : idx_q + 4'd1;
			end
			// count words of this item, saturating at the cap
			if (accept) begin
				step_q <= '0;
			end else if (cmd.emit && !cmd.drop) begin
				step_q <= step_q + 6'd1;
			end
			if (cmd.start) begin
				pend_q <= 1'b1;
			end else if (cmd.pix_load) begin
				pend_q <= status.col_zero;
			end else if (cmd.emit && state_q == pse_pkg::ST_FILTER) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.sec   = pse_pkg::SEC_NONE;
		cmd.idx   = idx_q;
		state_d   = state_q;
		in_ready  = 1'b0;
		emitting  = 1'b0;
		last_idx  = '0;
		after     = state_q;
		accept    = 1'b0;

		// pick the section, its length and the state that follows it
		case (state_q)
			pse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept    = 1'b1;
					cmd.start = 1'b1;
					state_d   = pse_pkg::ST_MUL;
				end
			end
			pse_pkg::ST_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept       = 1'b1;
					cmd.pix_load = 1'b1;
					state_d      = pse_pkg::ST_RAW_DEC;
				end
			end
			pse_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = pse_pkg::ST_DIVS;
			end
			pse_pkg::ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = pse_pkg::ST_DIV;
			end
			pse_pkg::ST_DIV: begin
				if (status.div_done) begin
					cmd.len_load = 1'b1;
					state_d      = pse_pkg::ST_SIG;
				end
			end
			pse_pkg::ST_SIG: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_SIG;
				last_idx = 4'd7; after = pse_pkg::ST_IHDR_LEN;
			end
			pse_pkg::ST_IHDR_LEN: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_LEN_IHDR;
				last_idx = 4'd3; after = pse_pkg::ST_IHDR_TAG;
			end
			pse_pkg::ST_IHDR_TAG: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_TAG_IHDR;
				last_idx = 4'd3; after = pse_pkg::ST_IHDR_BODY;
			end
			pse_pkg::ST_IHDR_BODY: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_IHDR_BODY;
				last_idx = 4'd12; after = pse_pkg::ST_IHDR_CRC;
			end
			pse_pkg::ST_IHDR_CRC: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_CRC;
				last_idx = 4'd3; after = pse_pkg::ST_IDAT_LEN;
			end
			pse_pkg::ST_IDAT_LEN: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_LEN_IDAT;
				last_idx = 4'd3; after = pse_pkg::ST_IDAT_TAG;
			end
			pse_pkg::ST_IDAT_TAG: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_TAG_IDAT;
				last_idx = 4'd3; after = pse_pkg::ST_ZHDR;
			end
			pse_pkg::ST_ZHDR: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_ZHDR;
				last_idx = 4'd1; after = pse_pkg::ST_RAW_DEC;
			end
			pse_pkg::ST_RAW_DEC: begin
				// open a stored block first when the current one is used up
				if (status.block_zero) begin
					state_d = pse_pkg::ST_BLK_HDR;
				end else if (pend_q) begin
					state_d = pse_pkg::ST_FILTER;
				end else begin
					state_d = pse_pkg::ST_PIXEL;
				end
			end
			pse_pkg::ST_BLK_HDR: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_BLK_HDR;
				last_idx = 4'd4; after = pse_pkg::ST_RAW_DEC;
			end
			pse_pkg::ST_FILTER: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_FILTER;
				last_idx = 4'd0; after = pse_pkg::ST_RAW_DEC;
			end
			pse_pkg::ST_PIXEL: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_PIXEL;
				last_idx = 4'd0;
				after    = status.pix_last ? pse_pkg::ST_ADLER : pse_pkg::ST_WAIT;
				cmd.last = !status.pix_last;
			end
			pse_pkg::ST_ADLER: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_ADLER;
				last_idx = 4'd3; after = pse_pkg::ST_IDAT_CRC;
			end
			pse_pkg::ST_IDAT_CRC: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_CRC;
				last_idx = 4'd3; after = pse_pkg::ST_IEND_LEN;
			end
			pse_pkg::ST_IEND_LEN: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_LEN_IEND;
				last_idx = 4'd3; after = pse_pkg::ST_IEND_TAG;
			end
			pse_pkg::ST_IEND_TAG: begin
				emitting = 1'b1; cmd.sec = pse_pkg::SEC_TAG_IEND;
				last_idx = 4'd3; after = pse_pkg::ST_IEND_CRC;
			end
			pse_pkg::ST_IEND_CRC: begin
				emitting    = 1'b1; cmd.sec = pse_pkg::SEC_CRC;
				last_idx    = 4'd3; after = pse_pkg::ST_IDLE;
				cmd.last    = idx_q == 4'd3;
				cmd.img_end = idx_q == 4'd3;
			end
			default: begin
				state_d = pse_pkg::ST_IDLE;
			end
		endcase

		// one byte per free output slot; words past the cap are computed but dropped
		cmd.emit = emitting && status.out_free;
		cmd.drop = step_q >= pse_pkg::MAX_WORDS;
		if (step_q == pse_pkg::MAX_WORDS - 6'd1) begin
			cmd.last = 1'b1;
		end
		if (!emitting) begin
			cmd.last    = 1'b0;
			cmd.img_end = 1'b0;
		end
		sec_done = idx_q == last_idx;
		if (cmd.emit && sec_done) begin
			state_d = after;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pse_datapath
// Image geometry, block and row counters, CRC-32, Adler-32 and output word.
// ---------------------------------------------------------------------------
module pse_datapath #(
	parameter int MAX_WIDTH   = 8192,
	parameter int MAX_HEIGHT  = 8192
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pse_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [pse_pkg::DIM_W-1:0]       cfg_val,
	input  wire logic [7:0]                      pix_in,
	input  wire pse_pkg::cmd_t                   cmd,
	output pse_pkg::status_t                     status,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           out_byte,
	output logic                                 out_last,
	output logic                                 out_img_end
);

	localparam logic [pse_pkg::DIM_W-1:0] MAX_W    = pse_pkg::DIM_W'(MAX_WIDTH);
	localparam logic [pse_pkg::DIM_W-1:0] MAX_H    = pse_pkg::DIM_W'(MAX_HEIGHT);
	localparam logic [pse_pkg::RAW_W-1:0] BLK_RAW  = pse_pkg::RAW_W'(pse_pkg::BLOCK_BYTES);
	localparam logic [pse_pkg::BLK_W-1:0] BLK_SIZE = pse_pkg::BLK_W'(pse_pkg::BLOCK_BYTES);

	logic [pse_pkg::DIM_W-1:0]  width_cfg_q, height_cfg_q;
	logic [pse_pkg::DIM_W-1:0]  cur_w_q, cur_h_q;
	logic [pse_pkg::RAW_W-1:0]  raw_q, raw_left_q;
	logic [31:0]                idat_len_q;
	logic [pse_pkg::COL_W-1:0]  col_q;
	logic [pse_pkg::ROW_W-1:0]  row_q;
	logic [pse_pkg::BLK_W-1:0]  block_left_q;
	logic [31:0]                crc_q;
	logic [15:0]                adler_lo_q, adler_hi_q;
	logic [7:0]                 pix_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_last_q, out_img_end_q;

	logic [pse_pkg::DIM_W-1:0]  w_clamp, h_clamp;
	logic [pse_pkg::COL_W-1:0]  line_len;
	logic [pse_pkg::DIVD_W-1:0] raw_prod;
	logic [pse_pkg::DIVD_W-1:0] div_quot;
	logic                       div_done;
	logic [pse_pkg::BLK_W-1:0]  blk_n;
	logic                       blk_final;
	logic [7:0]                 byte_d;
	logic                       crc_use;
	logic [31:0]                crc_in;
	logic [16:0]                lo_sum, hi_sum;
	logic [15:0]                lo_next, hi_next;
	logic                       row_end, row_last;
	logic                       raw_byte;
	logic [1:0]                 bi;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= 14'd256;
			height_cfg_q <= 14'd256;
		end else if (cfg_we) begin
			if (cfg_idx == pse_pkg::REG_WIDTH) begin
				width_cfg_q <= cfg_val;
			end else if (cfg_idx == pse_pkg::REG_HEIGHT) begin
				height_cfg_q <= cfg_val;
			end
		end
	end

	// clamp geometry into its legal range
	always_comb begin
		w_clamp = (width_cfg_q == '0) ? 14'd1 : ((width_cfg_q > MAX_W) ? MAX_W : width_cfg_q);
		h_clamp = (height_cfg_q == '0) ? 14'd1 :
			((height_cfg_q > MAX_H) ? MAX_H : height_cfg_q);
	end

	assign line_len = 15'(cur_w_q) + 15'({cur_w_q, 1'b0});
	assign raw_prod = pse_pkg::DIVD_W'(line_len + 15'd1) * pse_pkg::DIVD_W'(cur_h_q);

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (pse_pkg::DIVD_W'(raw_q) + pse_pkg::DIVD_W'(BLK_RAW) - 29'd1),
		.quotient (div_quot),
		.done     (div_done)
	);

	// stored block header fields
	assign blk_n     = (raw_left_q > BLK_RAW) ? BLK_SIZE : raw_left_q[pse_pkg::BLK_W-1:0];
	assign blk_final = raw_left_q <= BLK_RAW;

	assign bi       = cmd.idx[1:0];
	assign row_end  = {1'b0, col_q} == ({1'b0, line_len} - 16'd1);
	assign row_last = {1'b0, row_q} == (cur_h_q - 14'd1);

	// select the byte of the current section
	always_comb begin
		byte_d  = 8'd0;
		crc_use = 1'b1;
		case (cmd.sec)
			pse_pkg::SEC_SIG: begin
				byte_d  = pse_pkg::PNG_SIG[cmd.idx[2:0]];
				crc_use = 1'b0;
			end
			pse_pkg::SEC_LEN_IHDR: begin
				byte_d  = pse_pkg::be_byte(pse_pkg::IHDR_LEN, bi);
				crc_use = 1'b0;
			end
			pse_pkg::SEC_LEN_IDAT: begin
				byte_d  = pse_pkg::be_byte(idat_len_q, bi);
				crc_use = 1'b0;
			end
			pse_pkg::SEC_LEN_IEND: begin
				byte_d  = pse_pkg::be_byte(pse_pkg::IEND_LEN, bi);
				crc_use = 1'b0;
			end
			pse_pkg::SEC_CRC: begin
				byte_d  = pse_pkg::be_byte(crc_q ^ pse_pkg::ALL_ONES, bi);
				crc_use = 1'b0;
			end
			pse_pkg::SEC_TAG_IHDR: byte_d = pse_pkg::TAG_IHDR[bi];
			pse_pkg::SEC_TAG_IDAT: byte_d = pse_pkg::TAG_IDAT[bi];
			pse_pkg::SEC_TAG_IEND: byte_d = pse_pkg::TAG_IEND[bi];
			pse_pkg::SEC_IHDR_BODY: begin
				if (cmd.idx < 4'd4) begin
					byte_d = pse_pkg::be_byte({18'd0, cur_w_q}, bi);
				end else if (cmd.idx < 4'd8) begin
					byte_d = pse_pkg::be_byte({18'd0, cur_h_q}, bi);
				end else if (cmd.idx == 4'd8) begin
					byte_d = pse_pkg::IHDR_DEPTH;
				end else if (cmd.idx == 4'd9) begin
					byte_d = pse_pkg::IHDR_CTYPE;
				end
			end
			pse_pkg::SEC_ZHDR: byte_d = (cmd.idx == 4'd0) ? pse_pkg::ZLIB_CMF : pse_pkg::ZLIB_FLG;
			pse_pkg::SEC_BLK_HDR: begin
				case (cmd.idx)
					4'd0: byte_d = {7'd0, blk_final};
					4'd1: byte_d = blk_n[7:0];
					4'd2: byte_d = blk_n[15:8];
					4'd3: byte_d = ~blk_n[7:0];
					default: byte_d = ~blk_n[15:8];
				endcase
			end
			pse_pkg::SEC_FILTER: byte_d = 8'd0;
			pse_pkg::SEC_PIXEL:  byte_d = pix_q;
			pse_pkg::SEC_ADLER:  byte_d = pse_pkg::be_byte({adler_hi_q, adler_lo_q}, bi);
			default: begin
				byte_d  = 8'd0;
				crc_use = 1'b0;
			end
		endcase
	end

	// chunk CRC restarts at the first tag byte
	assign crc_in = ((cmd.sec == pse_pkg::SEC_TAG_IHDR || cmd.sec == pse_pkg::SEC_TAG_IDAT ||
		cmd.sec == pse_pkg::SEC_TAG_IEND) && cmd.idx == 4'd0) ? pse_pkg::ALL_ONES : crc_q;

	// Adler-32 sums, one reduction step each
	always_comb begin
		lo_sum  = {1'b0, adler_lo_q} + {9'd0, byte_d};
		lo_next = (lo_sum >= pse_pkg::ADLER_MOD) ? 16'(lo_sum - pse_pkg::ADLER_MOD) : lo_sum[15:0];
		hi_sum  = {1'b0, adler_hi_q} + {1'b0, lo_next};
		hi_next = (hi_sum >= pse_pkg::ADLER_MOD) ? 16'(hi_sum - pse_pkg::ADLER_MOD) : hi_sum[15:0];
	end

	assign raw_byte = cmd.emit && (cmd.sec == pse_pkg::SEC_FILTER || cmd.sec == pse_pkg::SEC_PIXEL);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			block_left_q <= '0;
			raw_left_q   <= '0;
			crc_q        <= pse_pkg::ALL_ONES;
			adler_lo_q   <= 16'd1;
			adler_hi_q   <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				col_q        <= '0;
				row_q        <= '0;
				block_left_q <= '0;
				adler_lo_q   <= 16'd1;
				adler_hi_q   <= 16'd0;
			end
			if (cmd.mul) begin
				raw_left_q <= raw_prod[pse_pkg::RAW_W-1:0];
			end
			if (cmd.emit && crc_use) begin
				crc_q <= pse_pkg::crc_byte(crc_in, byte_d);
			end
			if (cmd.emit && cmd.sec == pse_pkg::SEC_BLK_HDR && cmd.idx == 4'd4) begin
				block_left_q <= blk_n;
			end
			if (raw_byte) begin
				adler_lo_q <= lo_next;
				adler_hi_q <= hi_next;
				// the last pixel byte of the image clears the block state
				if (cmd.sec == pse_pkg::SEC_PIXEL && row_end && row_last) begin
					raw_left_q   <= '0;
					block_left_q <= '0;
				end else begin
					if (block_left_q != '0) block_left_q <= block_left_q - 16'd1;
					if (raw_left_q != '0) raw_left_q <= raw_left_q - 28'd1;
				end
			end
			// advance column and row on a pixel byte
			if (cmd.emit && cmd.sec == pse_pkg::SEC_PIXEL) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + 13'd1;
				end else begin
					col_q <= col_q + 15'd1;
				end
			end
			// output word slot
			if (cmd.emit && !cmd.drop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_w_q <= w_clamp;
			cur_h_q <= h_clamp;
		end
		if (cmd.start || cmd.pix_load) begin
			pix_q <= pix_in;
		end
		if (cmd.mul) begin
			raw_q <= raw_prod[pse_pkg::RAW_W-1:0];
		end
		if (cmd.len_load) begin
			idat_len_q <= 32'(raw_q) + 32'd6 + {1'b0, div_quot, 2'b00} + 32'(div_quot);
		end
		if (cmd.emit && !cmd.drop) begin
			out_byte_q    <= byte_d;
			out_last_q    <= cmd.last;
			out_img_end_q <= cmd.img_end;
		end
	end

	always_comb begin
		status.out_free   = !out_valid_q || out_ready;
		status.div_done   = div_done;
		status.block_zero = block_left_q == '0;
		status.col_zero   = col_q == '0;
		status.pix_last   = row_end && row_last;
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign out_last    = out_last_q;
	assign out_img_end = out_img_end_q;

endmodule
`default_nettype wire

### hw/rtl/png_stored_rgb_encoder_core.sv
// The first byte of an image goes through the size multiply and the stored block count for
// the IDAT length, then 43 header bytes go out at one per cycle while the output slot is
// free. Body items: accept, block check, emit; a row filter byte or a due stored block
// header adds a block check and its own bytes. The last item adds 20 trailer bytes.
// Output words stall with m_tready; the output register frees at the same edge it drains.
// Reset (arst_n low, asynchronous): no image open, width and height back to 256.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// png_stored_rgb_encoder_core
// Streams RGB8 pixel bytes in and a complete PNG file with stored deflate out.
// ---------------------------------------------------------------------------
module png_stored_rgb_encoder_core #(
	parameter int MAX_WIDTH   = 8192,
	parameter int MAX_HEIGHT  = 8192
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pse_pkg::DIM_W-1:0]      cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] pixel_byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,   // [7:0] out_byte
	output logic                                m_tlast,   // run_end
	output logic                                m_tuser    // [0] image_end
);

	pse_pkg::cmd_t    cmd;
	pse_pkg::status_t status;

	assign cfg_ready = 1'b1;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pse_datapath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_val     (cfg_data),
		.pix_in      (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.out_last    (m_tlast),
		.out_img_end (m_tuser)
	);

	// image end always closes a run
	a_img_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end word without run end");

	// one item at a time: no input right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

	// a byte is produced only when the output slot can take it
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("byte emitted into a full output slot");

	// a pending word is not overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !cmd.emit)
		else $error("output word overrun");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the PNG stored RGB encoder. It streams pixel bytes
// of many small images and the start of an oversized one, predicts every PNG
// byte with run and image markers, and checks the output stream word by word
// under random idling and backpressure.
// ---------------------------------------------------------------------------
module tb;
	import pse_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [7:0] data;
		logic       run_end;
		logic       image_end;
	} png_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	png_word_t png_q[$];
	png_word_t step_q[$];
	int err_cnt = 0;
	int src_idle = 0;
	int snk_idle = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int stall_cnt = 0;

	// encoder copy: registers and per-image state
	logic [DIM_W-1:0] reg_width = 14'd256;
	logic [DIM_W-1:0] reg_height = 14'd256;
	bit          img_open = 0;
	int unsigned img_w, img_h, col_cnt, row_cnt, blk_left, raw_left;
	logic [31:0] crc;
	logic [31:0] adler_lo, adler_hi;

	png_stored_rgb_encoder_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// ---------------- byte stream prediction ----------------

	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
		end
		return r;
	endfunction

	task automatic emit(input logic [7:0] b, input bit in_crc);
		png_word_t w;
		if (in_crc) begin
			crc = crc_next(crc, b);
		end
		w.data = b;
		w.run_end = 1'b0;
		w.image_end = 1'b0;
		step_q.push_back(w);
	endtask

	task automatic emit_be32(input logic [31:0] v, input bit in_crc);
		emit(v[31:24], in_crc);
		emit(v[23:16], in_crc);
		emit(v[15:8], in_crc);
		emit(v[7:0], in_crc);
	endtask

	task automatic open_chunk(input logic [31:0] len, input logic [7:0] tag [4]);
		emit_be32(len, 0);
		crc = 32'hffffffff;
		for (int i = 0; i < 4; i++) begin
			emit(tag[i], 1);
		end
	endtask

	task automatic close_chunk();
		emit_be32(crc ^ 32'hffffffff, 0);
	endtask

	// one byte of zlib raw data, with a stored block header when one is due
	task automatic emit_raw(input logic [7:0] b);
		int unsigned n;
		logic [15:0] nn;
		if (blk_left == 0) begin
			n = (raw_left > 65535) ? 65535 : raw_left;
			nn = ~n[15:0];
			emit((raw_left <= 65535) ? 8'd1 : 8'd0, 1);
			emit(n[7:0], 1);
			emit(n[15:8], 1);
			emit(nn[7:0], 1);
			emit(nn[15:8], 1);
			blk_left = n;
		end
		emit(b, 1);
		adler_lo = (adler_lo + b) % 65521;
		adler_hi = (adler_hi + adler_lo) % 65521;
		if (blk_left != 0) blk_left--;
		if (raw_left != 0) raw_left--;
	endtask

	// predict all words caused by one accepted pixel byte
	task automatic encode_pixel(input logic [7:0] pix);
		int unsigned raw, blocks;
		step_q.delete();
		if (!img_open) begin
			img_w = (reg_width == 0) ? 1 : (reg_width > 8192) ? 8192 : reg_width;
			img_h = (reg_height == 0) ? 1 : (reg_height > 8192) ? 8192 : reg_height;
			raw = (1 + 3 * img_w) * img_h;
			blocks = (raw + 65534) / 65535;
			raw_left = raw;
			blk_left = 0;
			col_cnt = 0;
			row_cnt = 0;
			adler_lo = 1;
			adler_hi = 0;
			img_open = 1;
			for (int i = 0; i < 8; i++) begin
				emit(PNG_SIG[i], 0);
			end
			open_chunk(IHDR_LEN, TAG_IHDR);
			emit_be32(img_w, 1);
			emit_be32(img_h, 1);
			emit(IHDR_DEPTH, 1);
			emit(IHDR_CTYPE, 1);
			emit(8'd0, 1);
			emit(8'd0, 1);
			emit(8'd0, 1);
			close_chunk();
			open_chunk(6 + raw + 5 * blocks, TAG_IDAT);
			emit(ZLIB_CMF, 1);
			emit(ZLIB_FLG, 1);
		end
		if (col_cnt == 0) emit_raw(8'd0);
		emit_raw(pix);
		col_cnt++;
		if (col_cnt >= 3 * img_w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= img_h) begin
				emit_be32({adler_hi[15:0], adler_lo[15:0]}, 1);
				close_chunk();
				open_chunk(IEND_LEN, TAG_IEND);
				close_chunk();
				step_q[step_q.size() - 1].image_end = 1'b1;
				img_open = 0;
				raw_left = 0;
				blk_left = 0;
			end
		end
		step_q[step_q.size() - 1].run_end = 1'b1;
		foreach (step_q[i]) png_q.push_back(step_q[i]);
	endtask

	// ---------------- drivers ----------------

	// send one pixel byte, with random idle cycles ahead of it
	task automatic send_pixel(input logic [7:0] v);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		encode_pixel(v);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_WIDTH) reg_width = val;
		else if (idx == REG_HEIGHT) reg_height = val;
	endtask

	// hold the sender until every predicted word has been seen
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (png_q.size() != 0) @(posedge clk);
	endtask

	// send one whole image of random bytes at the given register settings
	task automatic send_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		int unsigned n;
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		n = 3 * ((w == 0) ? 1 : (w > 8192) ? 8192 : w) * ((h == 0) ? 1 : (h > 8192) ? 8192 : h);
		for (int unsigned i = 0; i < n; i++) begin
			send_pixel(8'($urandom_range(0, 255)));
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_pixel_extremes();
		logic [7:0] vals [12] = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h01, 8'h80,
			8'hfe, 8'h7f, 8'h00, 8'hff, 8'h0f, 8'hf0};
		drain();
		write_reg(REG_WIDTH, 14'd2);
		write_reg(REG_HEIGHT, 14'd2);
		foreach (vals[i]) send_pixel(vals[i]);
	endtask

	task automatic test_dimension_limits();
		send_image(14'd0, 14'd0);
		send_image(14'd1, 14'd1);
		// unknown indexes must leave width and height alone
		drain();
		write_reg(2'd2, 14'h3fff);
		write_reg(2'd3, 14'h2aaa);
		for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_images(input int src, input int snk, input int count);
		int sent;
		src_idle = src;
		snk_idle = snk;
		sent = 0;
		while (sent < count) begin
			int w, h;
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			send_image(DIM_W'(w), DIM_W'(h));
			sent += 3 * w * h;
		end
	endtask

	task automatic test_output_hold();
		src_idle = 0;
		snk_idle = 0;
		drain();
		write_reg(REG_WIDTH, 14'd10);
		write_reg(REG_HEIGHT, 14'd3);
		hold_req++;
		for (int i = 0; i < 90; i++) send_pixel(8'($urandom_range(0, 255)));
	endtask

	// an oversized image clamps to the maximum and opens with a non-final stored block
	task automatic test_oversize_image();
		src_idle = 0;
		snk_idle = 0;
		drain();
		write_reg(REG_WIDTH, 14'h3fff);
		write_reg(REG_HEIGHT, 14'h3fff);
		for (int i = 0; i < 60; i++) send_pixel(8'($urandom_range(0, 255)));
	endtask

	// ---------------- output side ----------------

	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	// compare each output word with the oldest prediction
	always @(posedge clk) begin
		png_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (png_q.size() == 0) begin
				$display("%0t: unexpected word expected none actual %02h last %b end %b",
					$realtime, m_tdata, m_tlast, m_tuser);
				err_cnt++;
			end else begin
				w = png_q.pop_front();
				if (m_tdata !== w.data || m_tlast !== w.run_end || m_tuser !== w.image_end) begin
					$display("%0t: mismatch expected %02h/%b/%b actual %02h/%b/%b",
						$realtime, w.data, w.run_end, w.image_end, m_tdata, m_tlast, m_tuser);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_extremes();
		test_dimension_limits();
		test_random_images(24, 46, 80);
		test_random_images(46, 24, 80);
		test_random_images(0, 0, 80);
		test_output_hold();
		test_oversize_image();
		drain();
		repeat (50) @(posedge clk);
		if (err_cnt == 0 && png_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
